// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SPQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPQ_ASSERT(lbl, clk, rstn, prop)
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  cell_row;
        logic [7:0]  cell_col;
        logic [31:0] sched_time;
    } req_word_t;

    typedef struct packed {
        logic [7:0]  out_row;
        logic [7:0]  out_col;
        logic [31:0] out_time;
        status_t     status;
        logic        queue_empty;
        logic [6:0]  entry_count;
    } rsp_word_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic rsp_blocked;
    } stat_t;

endpackage

`default_nettype wire

// ----- rtl/spq_ctrl.sv -----
`default_nettype none

module spq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire spq_pkg::stat_t stat,
    output spq_pkg::cmd_t       cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_stall   = 1'b1;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC:
            begin
                if (!stat.rsp_blocked)
                begin
                    cmd.exec   = 1'b1;
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/spq_dp.sv -----
`default_nettype none

module spq_dp #(
    parameter int QUEUE_DEPTH = 64,
    parameter int GRID_DIM    = 256,
    parameter int TIME_BITS   = 32,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire spq_pkg::cmd_t        cmd,
    input  wire spq_pkg::req_word_t   req_word,
    input  wire logic                 rsp_stall,
    output logic                      rsp_valid,
    output spq_pkg::rsp_word_t        rsp_word,
    output spq_pkg::stat_t            stat,
    output logic [CNT_W-1:0]          count
);

    localparam logic [7:0] COORD_MAX = (GRID_DIM >= 256) ? 8'hFF : 8'(GRID_DIM - 1);
    localparam logic [63:0] TIME_MAX = (TIME_BITS >= 64) ? {64{1'b1}}
                                     : ((64'd1 << TIME_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    spq_pkg::req_word_t   req_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    spq_pkg::rsp_word_t   rsp_reg;
    spq_pkg::rsp_word_t   rsp_next;

    logic [7:0]           row_reg  [QUEUE_DEPTH];
    logic [7:0]           col_reg  [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] time_reg [QUEUE_DEPTH];
    logic [7:0]           row_next [QUEUE_DEPTH];
    logic [7:0]           col_next [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] time_next[QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] ins;
    logic [7:0]             new_row;
    logic [7:0]             new_col;
    logic [63:0]            sat_time;
    logic [TIME_BITS-1:0]   new_time;
    logic                   is_full;
    logic                   is_empty;
    logic                   do_push;
    logic                   do_pop;

    assign new_row  = (req_reg.cell_row > COORD_MAX) ? COORD_MAX : req_reg.cell_row;
    assign new_col  = (req_reg.cell_col > COORD_MAX) ? COORD_MAX : req_reg.cell_col;
    assign sat_time = (64'(req_reg.sched_time) > TIME_MAX) ? TIME_MAX
                    : 64'(req_reg.sched_time);
    assign new_time = sat_time[TIME_BITS-1:0];

    assign is_full  = (count_reg == CNT_FULL);
    assign is_empty = (count_reg == '0);
    assign do_push  = cmd.exec && (req_reg.req_type == spq_pkg::REQ_PUSH) && !is_full;
    assign do_pop   = cmd.exec && (req_reg.req_type == spq_pkg::REQ_POP) && !is_empty;

    // insertion mask: set from the first later entry onward, and past the tail
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            assign ins[g] = (CNT_W'(g) >= count_reg) || (time_reg[g] > new_time);

            always_comb
            begin
                row_next[g]  = row_reg[g];
                col_next[g]  = col_reg[g];
                time_next[g] = time_reg[g];
                if (do_push && ins[g])
                begin
                    if (g == 0)
                    begin
                        row_next[g]  = new_row;
                        col_next[g]  = new_col;
                        time_next[g] = new_time;
                    end
                    else if (!ins[(g == 0) ? 0 : g - 1])
                    begin
                        row_next[g]  = new_row;
                        col_next[g]  = new_col;
                        time_next[g] = new_time;
                    end
                    else
                    begin
                        row_next[g]  = row_reg[(g == 0) ? 0 : g - 1];
                        col_next[g]  = col_reg[(g == 0) ? 0 : g - 1];
                        time_next[g] = time_reg[(g == 0) ? 0 : g - 1];
                    end
                end
                else if (do_pop && (g < QUEUE_DEPTH - 1))
                begin
                    row_next[g]  = row_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                    col_next[g]  = col_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                    time_next[g] = time_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                end
            end

            always_ff @(posedge clk)
            begin
                row_reg[g]  <= row_next[g];
                col_reg[g]  <= col_next[g];
                time_reg[g] <= time_next[g];
            end
        end
    endgenerate

    always_comb
    begin
        count_next           = count_reg;
        rsp_next.out_row     = '0;
        rsp_next.out_col     = '0;
        rsp_next.out_time    = '0;
        rsp_next.status      = spq_pkg::ST_OK;
        case (req_reg.req_type)
            spq_pkg::REQ_PUSH:
            begin
                if (is_full)
                begin
                    rsp_next.status = spq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            spq_pkg::REQ_POP, spq_pkg::REQ_PEEK:
            begin
                if (is_empty)
                begin
                    rsp_next.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    rsp_next.out_row  = row_reg[0];
                    rsp_next.out_col  = col_reg[0];
                    rsp_next.out_time = 32'(time_reg[0]);
                    if (req_reg.req_type == spq_pkg::REQ_POP)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.queue_empty = (count_next == '0);
        rsp_next.entry_count = 7'(count_next);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.exec)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_word;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign rsp_word         = rsp_reg;
    assign stat.rsp_blocked = rsp_valid_reg && rsp_stall;
    assign count            = count_reg;

endmodule

`default_nettype wire

// ----- rtl/sorted_event_priority_queue_top.sv -----
// channel | valid     | stall     | word
// --------+-----------+-----------+---------------------------
// request | req_valid | req_stall | req_word (spq_pkg::req_word_t)
// result  | rsp_valid | rsp_stall | rsp_word (spq_pkg::rsp_word_t)
//
// Each word goes in order: the request is captured, then the
// compare-and-shift runs over every store cell in parallel and also loads
// the result register; no new request is taken until that step is done. One result word per request word.
// Reset empties the queue; no clearing pass.
// A held result stalls only the next execute step; a request may be taken meanwhile.
`default_nettype none

`include "assert_macros.svh"

module sorted_event_priority_queue_top #(
    parameter int QUEUE_DEPTH = 64,
    parameter int GRID_DIM    = 256,
    parameter int TIME_BITS   = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire spq_pkg::req_word_t req_word,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output spq_pkg::rsp_word_t      rsp_word
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    spq_pkg::cmd_t    cmd;
    spq_pkg::stat_t   stat;
    logic [CNT_W-1:0] count;
    logic             rsp_full;
    logic             at_full;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .GRID_DIM    (GRID_DIM),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_word  (req_word),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_word  (rsp_word),
        .stat      (stat),
        .count     (count)
    );

    assign rsp_full = rsp_valid && (rsp_word.status == spq_pkg::ST_FULL);
    assign at_full  = (count == CNT_W'(QUEUE_DEPTH));

    `SPQ_ASSERT(a_count_bound, clk, rst_n, count <= CNT_W'(QUEUE_DEPTH))
    `SPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)
    `SPQ_ASSERT(a_full_flag, clk, rst_n, !rsp_full || at_full)

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         QUEUE_DEPTH = 64;
    localparam logic [1:0] REQ_NOP     = 2'd3;
    localparam int         NUM_ITEMS   = 1100;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    class event_queue_scoreboard;
        spq_pkg::req_word_t sched_events[$];
        spq_pkg::rsp_word_t expected_rsp[$];
        int        errors;
        int        results_checked;
        int        n_push;
        int        n_pop;
        int        n_peek;
        int        n_nop;
        int        n_full;
        int        n_empty;
        int        peak_count;

        function new();
            errors          = 0;
            results_checked = 0;
            n_push          = 0;
            n_pop           = 0;
            n_peek          = 0;
            n_nop           = 0;
            n_full          = 0;
            n_empty         = 0;
            peak_count      = 0;
        endfunction

        function void note_request(spq_pkg::req_word_t w);
            spq_pkg::rsp_word_t r;
            int        pos;
            r        = '0;
            r.status = spq_pkg::ST_OK;
            case (w.req_type)
                spq_pkg::REQ_PUSH:
                begin
                    n_push++;
                    if (sched_events.size() >= QUEUE_DEPTH)
                    begin
                        r.status = spq_pkg::ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        // insert after every event with equal or earlier time
                        pos = sched_events.size();
                        for (int i = 0; i < sched_events.size(); i++)
                        begin
                            if (sched_events[i].sched_time > w.sched_time)
                            begin
                                pos = i;
                                break;
                            end
                        end
                        sched_events.insert(pos, w);
                    end
                end
                spq_pkg::REQ_POP, spq_pkg::REQ_PEEK:
                begin
                    if (w.req_type == spq_pkg::REQ_POP)
                        n_pop++;
                    else
                        n_peek++;
                    if (sched_events.size() == 0)
                    begin
                        r.status = spq_pkg::ST_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        r.out_row  = sched_events[0].cell_row;
                        r.out_col  = sched_events[0].cell_col;
                        r.out_time = sched_events[0].sched_time;
                        if (w.req_type == spq_pkg::REQ_POP)
                            void'(sched_events.pop_front());
                    end
                end
                default:
                begin
                    n_nop++;
                end
            endcase
            r.entry_count = 7'(sched_events.size());
            r.queue_empty = (sched_events.size() == 0);
            if (sched_events.size() > peak_count)
                peak_count = sched_events.size();
            expected_rsp.push_back(r);
        endfunction

        function void check_field(string fname, logic [31:0] exp, logic [31:0] act);
            if (act !== exp)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, fname, exp, act);
            end
        endfunction

        function void check_result(spq_pkg::rsp_word_t a);
            spq_pkg::rsp_word_t e;
            if (expected_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual 0x%0h",
                         $time, a);
                return;
            end
            e = expected_rsp.pop_front();
            results_checked++;
            check_field("out_row", e.out_row, a.out_row);
            check_field("out_col", e.out_col, a.out_col);
            check_field("out_time", e.out_time, a.out_time);
            check_field("status", e.status, a.status);
            check_field("queue_empty", e.queue_empty, a.queue_empty);
            check_field("entry_count", e.entry_count, a.entry_count);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    spq_pkg::req_word_t req_word;
    logic               rsp_valid;
    logic               rsp_stall;
    spq_pkg::rsp_word_t rsp_word;

    event_queue_scoreboard sb;
    bit idle_on;
    int hold_left;
    int items_sent;

    sorted_event_priority_queue_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: check accepted words, draw a stall length per word
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left = 0;
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                sb.check_result(rsp_word);
                hold_left = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic send_req(input spq_pkg::req_word_t w);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(w);
        items_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic spq_pkg::req_word_t push_word(logic [7:0] row, logic [7:0] col,
                                                     logic [31:0] t);
        spq_pkg::req_word_t w;
        w.req_type   = spq_pkg::REQ_PUSH;
        w.cell_row   = row;
        w.cell_col   = col;
        w.sched_time = t;
        return w;
    endfunction

    function automatic spq_pkg::req_word_t op_word(logic [1:0] op);
        spq_pkg::req_word_t w;
        logic [63:0]        raw;
        raw        = {$urandom, $urandom};
        w          = raw[$bits(spq_pkg::req_word_t)-1:0];
        w.req_type = op;
        return w;
    endfunction

    function automatic logic [31:0] rand_time();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return $urandom_range(0, 15);
        else if (pick < 45)
        begin
            case ($urandom_range(0, 2))
                0: return 32'h0;
                1: return 32'hFFFF_FFFF;
                default: return 32'hFFFF_FFFE;
            endcase
        end
        return $urandom;
    endfunction

    function automatic spq_pkg::req_word_t rand_req(traffic_mode_t mode);
        int pick;
        int push_pct;
        int pop_pct;
        pick = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                push_pct = 85;
                pop_pct  = 8;
            end
            MODE_DRAIN:
            begin
                push_pct = 15;
                pop_pct  = 68;
            end
            default:
            begin
                push_pct = 47;
                pop_pct  = 38;
            end
        endcase
        if (pick < push_pct)
            return push_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             rand_time());
        else if (pick < push_pct + pop_pct)
            return op_word(spq_pkg::REQ_POP);
        else if (pick < 98)
            return op_word(spq_pkg::REQ_PEEK);
        return op_word(REQ_NOP);
    endfunction

    initial
    begin
        traffic_mode_t mode;
        int            phase_len;
        int            phase;
        sb         = new();
        idle_on    = 1'b0;
        items_sent = 0;
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req_word   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty errors, no-op, field extremes, ties, drain
        send_req(op_word(spq_pkg::REQ_POP));
        send_req(op_word(spq_pkg::REQ_PEEK));
        send_req(op_word(REQ_NOP));
        send_req(push_word(8'hFF, 8'h00, 32'hFFFF_FFFF));
        send_req(push_word(8'h00, 8'hFF, 32'h0000_0000));
        send_req(push_word(8'h55, 8'hAA, 32'h0001_0000));
        send_req(push_word(8'hAA, 8'h55, 32'h0001_0000));
        send_req(push_word(8'h01, 8'h02, 32'h0001_0000));
        send_req(push_word(8'hFE, 8'hFE, 32'hFFFF_FFFF));
        send_req(op_word(spq_pkg::REQ_PEEK));
        send_req(op_word(REQ_NOP));
        send_req(op_word(spq_pkg::REQ_POP));
        send_req(op_word(spq_pkg::REQ_PEEK));
        send_req(op_word(spq_pkg::REQ_POP));
        send_req(op_word(spq_pkg::REQ_POP));
        send_req(op_word(spq_pkg::REQ_POP));
        send_req(op_word(spq_pkg::REQ_POP));
        send_req(op_word(spq_pkg::REQ_POP));
        send_req(op_word(spq_pkg::REQ_PEEK));
        wait_drained();

        phase = 0;
        while (items_sent < NUM_ITEMS)
        begin
            if (phase == 0)
                mode = MODE_FILL;
            else
                mode = traffic_mode_t'($urandom_range(0, 2));
            idle_on   = (phase == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
            phase_len = (mode == MODE_MIXED) ? $urandom_range(20, 60)
                                             : $urandom_range(60, 120);
            repeat (phase_len) send_req(rand_req(mode));
            if (phase % 4 == 3)
                wait_drained();
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Ran %0d requests: %0d push, %0d pop, %0d peek, %0d no-op; %0d results checked.",
                 items_sent, sb.n_push, sb.n_pop, sb.n_peek, sb.n_nop, sb.results_checked);
        $display("Rejected pushes on a full queue: %0d, pops/peeks on empty: %0d, peak depth %0d.",
                 sb.n_full, sb.n_empty, sb.peak_count);
        if (sb.errors == 0 && sb.expected_rsp.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Timeout waiting for the queue to finish");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
